/* design/median3_then_average_filter_core_assert.svh */
// assertion macros shared by the median-of-three mean filter
// depends on nothing; included by the top level only
`ifndef MEDIAN3_THEN_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MEDIAN3_THEN_AVERAGE_FILTER_CORE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define M3A_ASSERT_SAME(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define M3A_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* design/m3a_pkg.sv */
// package for the median-of-three mean filter: widths, divider length,
// controller/datapath command and status structs; depends on nothing
package m3a_pkg;

    // sample width actually used (low bits of the input word)
    localparam int SAMPLE_BITS  = 16;
    localparam int IN_BITS      = 16;
    localparam int OUT_BITS     = 16;
    localparam int COUNT_BITS   = 8;
    localparam int SUM_BITS     = 24;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // commands from controller to datapath
    typedef struct packed {
        logic accept;    // take the input word this cycle
        logic div_step;  // run one divider iteration
        logic out_load;  // load quotient into output register
    } m3a_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic emit;      // accepting this word closes the average
    } m3a_stat_t;

endpackage

/* design/median3_then_average_filter_core.sv */
// median-of-three then mean filter, top level. a word that does not close an
// average is taken while the controller is idle; the word closing an average
// holds off input through a 24-step serial divide and then the output load,
// which registers the result shown on m_tvalid. the load, and so the input,
// waits while an earlier result is still unread. synchronous active-low
// reset clears group position, sums, state and valid; group_count resets to 1.
module median3_then_average_filter_core
    import m3a_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,  // group_count
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BITS-1:0]    s_tdata,      // [15:0] sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_BITS-1:0]   m_tdata       // [15:0] filtered
);

    m3a_cmd_t  cmd;
    m3a_stat_t stat;

    m3a_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .filtered    (m_tdata)
    );

    m3a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // checks
`include "median3_then_average_filter_core_assert.svh"

    `M3A_ASSERT_NEXT(a_busy_after_close, aclk, aresetn, s_tvalid && s_tready && stat.emit, !s_tready, "input taken during divide")
    `M3A_ASSERT_SAME(a_load_not_accept, aclk, aresetn, cmd.out_load, !cmd.accept && !cmd.div_step, "output load overlaps other command")
    `M3A_ASSERT_SAME(a_rise_after_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result without a divide")

endmodule

/* design/m3a_datapath.sv */
// datapath: group register, median compare, accumulator, serial divider,
// output data register; depends on m3a_pkg
module m3a_datapath
    import m3a_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    input  logic [IN_BITS-1:0]    sample,
    input  m3a_cmd_t              cmd,
    output m3a_stat_t             stat,
    output logic [OUT_BITS-1:0]   filtered
);

    // position of a word inside its group of three
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [COUNT_BITS-1:0]  group_count_reg;
    logic [1:0]             phase_reg, phase_next;
    logic [SAMPLE_BITS-1:0] first_reg, second_reg;
    logic [COUNT_BITS-1:0]  groups_done_reg, groups_done_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SUM_BITS-1:0]    quot_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  den_reg;
    logic [OUT_BITS-1:0]    out_data_reg;

    logic [SAMPLE_BITS-1:0] s_cur;
    logic [SAMPLE_BITS-1:0] med_lo, med_hi, median;
    logic [COUNT_BITS-1:0]  gd_inc;
    logic [SUM_BITS-1:0]    sum_inc;
    logic                   third;
    logic [COUNT_BITS:0]    trial;
    logic                   trial_neg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_count_reg <= COUNT_BITS'(1);
        end else if (cfg_wr_en) begin
            group_count_reg <= cfg_wr_data;
        end
    end

    // median of three, comparison order as specified
    always_comb begin
        s_cur  = sample[SAMPLE_BITS-1:0];
        med_lo = first_reg;
        med_hi = second_reg;
        if (first_reg > second_reg) begin
            med_lo = second_reg;
            med_hi = first_reg;
        end
        if (s_cur > med_hi) begin
            median = med_hi;
        end else if (s_cur > med_lo) begin
            median = s_cur;
        end else begin
            median = med_lo;
        end
    end

    // group and accumulator next values
    // a group counter that wraps to zero keeps summing and emits nothing
    always_comb begin
        third      = (phase_reg == PH_THIRD);
        gd_inc     = groups_done_reg + COUNT_BITS'(1);
        sum_inc    = sum_reg + SUM_BITS'(median);
        stat.emit  = third && (gd_inc != '0) && (gd_inc >= group_count_reg);

        phase_next       = phase_reg;
        groups_done_next = groups_done_reg;
        sum_next         = sum_reg;
        if (cmd.accept) begin
            case (phase_reg)
                PH_SECOND: phase_next = PH_THIRD;
                PH_THIRD:  phase_next = PH_FIRST;
                default:   phase_next = PH_SECOND;
            endcase
            if (third) begin
                if (stat.emit) begin
                    groups_done_next = '0;
                    sum_next         = '0;
                end else begin
                    groups_done_next = gd_inc;
                    sum_next         = sum_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FIRST;
            groups_done_reg <= '0;
            sum_reg         <= '0;
        end else begin
            phase_reg       <= phase_next;
            groups_done_reg <= groups_done_next;
            sum_reg         <= sum_next;
        end
    end

    // sample holding registers
    always_ff @(posedge aclk) begin
        if (cmd.accept && (phase_reg == PH_SECOND)) begin
            second_reg <= s_cur;
        end else if (cmd.accept && !third) begin
            first_reg <= s_cur;
        end
    end

    // restoring divider trial subtract
    always_comb begin
        trial     = {rem_reg, quot_reg[SUM_BITS-1]} - {1'b0, den_reg};
        trial_neg = trial[COUNT_BITS];
    end

    // divider registers: loaded when the average closes, then shifted
    always_ff @(posedge aclk) begin
        if (cmd.accept && stat.emit) begin
            quot_reg <= sum_inc;
            den_reg  <= gd_inc;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[SUM_BITS-2:0], ~trial_neg};
            if (trial_neg) begin
                rem_reg <= {rem_reg[COUNT_BITS-2:0], quot_reg[SUM_BITS-1]};
            end else begin
                rem_reg <= trial[COUNT_BITS-1:0];
            end
        end
    end

    // output data register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= quot_reg[OUT_BITS-1:0];
        end
    end

    assign filtered = out_data_reg;

endmodule

/* design/m3a_ctrl.sv */
// controller: one-hot state machine sequencing accept, divide and output
// load, plus the output word valid flag; depends on m3a_pkg
module m3a_ctrl
    import m3a_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  m3a_stat_t stat,
    output m3a_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && stat.emit) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* tb/median3_then_average_filter_core_tb.sv */
// self-checking testbench for median3_then_average_filter_core: streams samples,
// predicts each filtered word in a small tracker class and compares in order
// depends on m3a_pkg and the core only
`timescale 1ns / 100ps

module median3_then_average_filter_core_tb
    import m3a_pkg::*;
;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF_LEN  = 300;

    // tracks group position and median sum, holds the filtered words still due
    class median_mean_tracker;
        logic [COUNT_BITS-1:0] group_count;
        logic [IN_BITS-1:0]    first_sample;
        logic [IN_BITS-1:0]    second_sample;
        logic [1:0]            slot;
        logic [COUNT_BITS-1:0] groups_done;
        logic [SUM_BITS-1:0]   median_sum;
        logic [OUT_BITS-1:0]   expected_means[$];
        int unsigned           mismatches;
        int unsigned           words_checked;

        function new();
            group_count   = COUNT_BITS'(1);
            first_sample  = '0;
            second_sample = '0;
            slot          = '0;
            groups_done   = '0;
            median_sum    = '0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void set_group_count(logic [COUNT_BITS-1:0] value);
            group_count = value;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function logic [IN_BITS-1:0] middle(logic [IN_BITS-1:0] a, logic [IN_BITS-1:0] b,
                                            logic [IN_BITS-1:0] c);
            if ((a >= b && a <= c) || (a <= b && a >= c))
                return a;
            if ((b >= a && b <= c) || (b <= a && b >= c))
                return b;
            return c;
        endfunction

        function void note_sample(logic [IN_BITS-1:0] raw);
            logic [IN_BITS-1:0]  s;
            logic [SUM_BITS-1:0] quotient;
            s = raw & IN_BITS'((32'd1 << SAMPLE_BITS) - 1);
            if (slot == 2'd1) begin
                second_sample = s;
                slot = 2'd2;
                return;
            end
            if (slot != 2'd2) begin
                first_sample = s;
                slot = 2'd1;
                return;
            end
            // third sample closes the group
            slot = 2'd0;
            median_sum  = median_sum + SUM_BITS'(middle(first_sample, second_sample, s));
            groups_done = groups_done + 1'b1;
            if (groups_done == 0 || groups_done < group_count)
                return;
            // divide by the groups actually summed, not the register
            quotient = median_sum / groups_done;
            expected_means.push_back(quotient[OUT_BITS-1:0]);
            median_sum  = '0;
            groups_done = '0;
        endfunction

        function void check_filtered(logic [OUT_BITS-1:0] actual);
            logic [OUT_BITS-1:0] want;
            if (expected_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected filtered word %h", actual);
                return;
            end
            want = expected_means.pop_front();
            words_checked++;
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on filtered: expected %h, got %h", want, actual);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [COUNT_BITS-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_BITS-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_BITS-1:0]   m_tdata;

    median_mean_tracker tracker = new();

    bit          gaps_on;
    bit          hold_off_req;
    int unsigned samples_sent;
    int unsigned count_writes;
    int unsigned cycle_count;
    logic [IN_BITS-1:0] prev_sample;

    median3_then_average_filter_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [15:0] sample
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)       // [15:0] filtered
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // known values on every input from time zero
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        samples_sent = 0;
        count_writes = 0;
        prev_sample  = '0;
    end

    // random sender gap with s_tvalid low and random data
    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_BITS'($urandom);
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
    endtask

    // offer one sample word and wait for the handshake
    task automatic send_sample(input logic [IN_BITS-1:0] value);
        sender_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_sample(value);
        samples_sent++;
        prev_sample = value;
        @(negedge aclk);
    endtask

    task automatic send_group(input logic [IN_BITS-1:0] a, input logic [IN_BITS-1:0] b,
                              input logic [IN_BITS-1:0] c);
        send_sample(a);
        send_sample(b);
        send_sample(c);
    endtask

    // write group_count once the block has drained and gone quiet
    task automatic program_group_count(input logic [COUNT_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_group_count(value);
        count_writes++;
    endtask

    // extremes and repeats to hit ties inside a group
    function automatic logic [IN_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return prev_sample;
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    // result side ready: random stalls, plus one long hold-off on request
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 18);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each accepted result word
    initial begin : result_check
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.check_filtered(m_tdata);
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL median3_then_average_filter_core");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int phase_idx;
        int n;
        int i;
        logic [COUNT_BITS-1:0] gc;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset count of one, extremes and equal samples
        send_group(16'h0000, 16'hFFFF, 16'h8000);
        send_group(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_group(16'h0005, 16'h0005, 16'h0003);
        send_group(16'h0009, 16'h0002, 16'h0009);

        // zero count behaves as one
        program_group_count(8'd0);
        send_group(16'hAAAA, 16'h5555, 16'h0001);

        // count lowered in the middle of an average
        program_group_count(8'd4);
        send_group(16'h1000, 16'h3000, 16'h2000);
        send_group(16'h7FFF, 16'h0100, 16'hFFFE);
        program_group_count(8'd2);
        send_group(16'h0300, 16'h0400, 16'h0200);

        // random phases
        for (phase_idx = 0; phase_idx < 10; phase_idx++) begin
            if (phase_idx == 9)
                gaps_on = 1'b0;
            if (phase_idx == 6) begin
                // largest count with near-full-scale samples
                program_group_count(8'd255);
                for (i = 0; i < 765; i++)
                    send_sample(($urandom_range(0, 3) == 0) ? 16'hFFFF
                                : IN_BITS'($urandom_range(16'hF000, 16'hFFFF)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       gc = 8'd1;
                    1:       gc = 8'd2;
                    2:       gc = 8'd3;
                    default: gc = COUNT_BITS'($urandom_range(4, 12));
                endcase
                if (phase_idx == 2)
                    gc = 8'd1;
                program_group_count(gc);
                // receiver holds off while words keep coming
                if (phase_idx == 2)
                    hold_off_req = 1'b1;
                n = $urandom_range(40, 70);
                for (i = 0; i < n; i++)
                    send_sample(pick_sample());
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("run covered %0d samples, %0d filtered words, %0d group_count writes",
                 samples_sent, tracker.words_checked, count_writes);
        $display("%0d mismatches in %0d cycles", tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("PASS median3_then_average_filter_core");
        end else begin
            $display("FAIL median3_then_average_filter_core");
        end
        $finish;
    end

endmodule
